FILE: design/rwbt_pkg.sv
// Package for the raster window buffer tracker: field widths, register map,
// reset values, start-mode codes and the structs shared between the stages.
// No dependencies.
`default_nettype none

package rwbt_pkg;

  localparam int COORD_W  = 12;  // pixel_x, pixel_y, box bounds
  localparam int DIM_W    = 13;  // frame_width, frame_height
  localparam int WP_W     = 25;  // window_pixels
  localparam int MODE_W   = 2;   // start_mode
  localparam int IDX_W    = 2 * DIM_W;  // linear index / frame size
  localparam int TOTAL_W  = 40;  // requests_total, reloads_total
  localparam int FLOW_W   = 27;  // fetches_low
  localparam int FHIGH_W  = 32;  // fetches_high
  localparam int FSUM_W   = FLOW_W + 1;
  localparam int FETCH_WRAP = 100000000;

  localparam int MAX_SIDE_DEF   = 4096;
  localparam int COUNT_BITS_DEF = 40;

  // APB register map
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_PIXELS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_MODE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y     = 3'd7;

  // reload start codes; the unused code behaves as MODE_PIXEL
  localparam logic [MODE_W-1:0] MODE_PIXEL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COLUMN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROW    = 2'd2;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH   = 13'd3840;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT  = 13'd2160;
  localparam logic [WP_W-1:0]    RST_WINDOW_PIXELS = 25'd214016;
  localparam logic [MODE_W-1:0]  RST_START_MODE    = MODE_PIXEL;
  localparam logic [COORD_W-1:0] RST_BOX_MIN       = 12'd0;
  localparam logic [COORD_W-1:0] RST_BOX_MAX       = 12'd4095;

  // configuration as seen by the datapath (frame sides already clamped)
  typedef struct packed {
    logic [DIM_W-1:0]   side_w;
    logic [DIM_W-1:0]   side_h;
    logic [IDX_W-1:0]   frame_total;
    logic [WP_W-1:0]    window_pixels;
    logic [MODE_W-1:0]  start_mode;
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_y;
  } cfg_t;

  // index stage -> window stage
  typedef struct packed {
    logic               counted;
    logic [COORD_W-1:0] x;
    logic [IDX_W-1:0]   row_base;
    logic [IDX_W-1:0]   idx;
  } idx_info_t;

  typedef struct packed {
    logic               counted;
    logic               hit;
    logic [TOTAL_W-1:0] requests_total;
    logic [TOTAL_W-1:0] reloads_total;
    logic [FLOW_W-1:0]  fetches_low;
    logic [FHIGH_W-1:0] fetches_high;
  } res_t;

endpackage

`default_nettype wire

FILE: design/rwbt_req_if.sv
// Request channel: pixel coordinates with a valid/ready handshake.
// Depends on rwbt_pkg.
`default_nettype none

interface rwbt_req_if;
  logic                        valid;
  logic                        ready;
  logic [rwbt_pkg::COORD_W-1:0] pixel_x;
  logic [rwbt_pkg::COORD_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

`default_nettype wire

FILE: design/rwbt_res_if.sv
// Result channel: hit flags and running counters, valid/ready handshake.
// Depends on rwbt_pkg.
`default_nettype none

interface rwbt_res_if;
  logic                         valid;
  logic                         ready;
  logic                         counted;
  logic                         hit;
  logic [rwbt_pkg::TOTAL_W-1:0] requests_total;
  logic [rwbt_pkg::TOTAL_W-1:0] reloads_total;
  logic [rwbt_pkg::FLOW_W-1:0]  fetches_low;
  logic [rwbt_pkg::FHIGH_W-1:0] fetches_high;

  modport source (output valid, counted, hit, requests_total, reloads_total,
                  fetches_low, fetches_high, input ready);
  modport sink   (input valid, counted, hit, requests_total, reloads_total,
                  fetches_low, fetches_high, output ready);
endinterface

`default_nettype wire

FILE: design/raster_window_buffer_tracker_unit.sv
// Raster window buffer tracker, top level.
// Depends on rwbt_pkg, rwbt_req_if, rwbt_res_if, rwbt_cfg_regs,
// rwbt_index_stage and rwbt_window_stage.
//
// Usage:
//   in_req  : pixel requests (pixel_x, pixel_y), one transfer per request.
//   out_res : one result per request, in order: counted, hit and the running
//             request, reload and fetch counters after that request.
//   APB     : eight 32-bit registers at byte address 4*i, written with the
//             usual setup/access pair; pready is always high.
// A request passes the input register, the row multiply and box test into
// the index register, then window compare / reload / counter update into
// the result register. Throughput is one request per cycle while out_res is
// not stalled; the window state feeds back only within the last stage.
// Reset (synchronous, rst_n low) loads the register defaults, empties the
// window and clears all counters. When out_res.ready is low the result
// register holds; the two earlier stages keep taking requests until they are
// full, after which in_req.ready drops until the result is taken.
// Registers are to be written while no request is in flight; the block does not enforce it.
`default_nettype none

module raster_window_buffer_tracker_unit #(
  parameter int MAX_SIDE   = rwbt_pkg::MAX_SIDE_DEF,
  parameter int COUNT_BITS = rwbt_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rwbt_req_if.sink                         in_req,
  rwbt_res_if.source                       out_res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rwbt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rwbt_pkg::DATA_W-1:0] pwdata,
  output logic      [rwbt_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  rwbt_pkg::cfg_t      cfg;
  rwbt_pkg::idx_info_t info;
  rwbt_pkg::res_t      res;
  logic                info_valid, info_ready;

  rwbt_cfg_regs #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rwbt_index_stage u_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .in_x       (in_req.pixel_x),
    .in_y       (in_req.pixel_y),
    .cfg        (cfg),
    .info_valid (info_valid),
    .info_ready (info_ready),
    .info       (info)
  );

  rwbt_window_stage #(
    .COUNT_BITS (COUNT_BITS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .info_valid (info_valid),
    .info_ready (info_ready),
    .info       (info),
    .res_valid  (out_res.valid),
    .res_ready  (out_res.ready),
    .res        (res)
  );

  assign out_res.counted        = res.counted;
  assign out_res.hit            = res.hit;
  assign out_res.requests_total = res.requests_total;
  assign out_res.reloads_total  = res.reloads_total;
  assign out_res.fetches_low    = res.fetches_low;
  assign out_res.fetches_high   = res.fetches_high;

endmodule

`default_nettype wire

FILE: design/rwbt_cfg_regs.sv
// APB configuration registers plus the registered frame size derived from them.
// Depends on rwbt_pkg.
`default_nettype none

module rwbt_cfg_regs #(
  parameter int MAX_SIDE = rwbt_pkg::MAX_SIDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rwbt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rwbt_pkg::DATA_W-1:0]   pwdata,
  output logic      [rwbt_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output rwbt_pkg::cfg_t                     cfg
);

  localparam int DW = rwbt_pkg::DIM_W;
  localparam int XW = rwbt_pkg::IDX_W;
  localparam int DATW = rwbt_pkg::DATA_W;

  logic [rwbt_pkg::DIM_W-1:0]   frame_width_r, frame_height_r;
  logic [rwbt_pkg::WP_W-1:0]    window_pixels_r;
  logic [rwbt_pkg::MODE_W-1:0]  start_mode_r;
  logic [rwbt_pkg::COORD_W-1:0] box_min_x_r, box_max_x_r, box_min_y_r, box_max_y_r;
  logic [rwbt_pkg::DIM_W-1:0]   side_w_r, side_h_r, side_w_nxt, side_h_nxt;
  logic [rwbt_pkg::IDX_W-1:0]   total_r;
  logic [rwbt_pkg::REG_IDX_W-1:0] reg_sel;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[rwbt_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= rwbt_pkg::RST_FRAME_WIDTH;
      frame_height_r  <= rwbt_pkg::RST_FRAME_HEIGHT;
      window_pixels_r <= rwbt_pkg::RST_WINDOW_PIXELS;
      start_mode_r    <= rwbt_pkg::RST_START_MODE;
      box_min_x_r     <= rwbt_pkg::RST_BOX_MIN;
      box_max_x_r     <= rwbt_pkg::RST_BOX_MAX;
      box_min_y_r     <= rwbt_pkg::RST_BOX_MIN;
      box_max_y_r     <= rwbt_pkg::RST_BOX_MAX;
    end else if (wr_en) begin
      case (reg_sel)
        rwbt_pkg::REG_FRAME_WIDTH:   frame_width_r   <= pwdata[rwbt_pkg::DIM_W-1:0];
        rwbt_pkg::REG_FRAME_HEIGHT:  frame_height_r  <= pwdata[rwbt_pkg::DIM_W-1:0];
        rwbt_pkg::REG_WINDOW_PIXELS: window_pixels_r <= pwdata[rwbt_pkg::WP_W-1:0];
        rwbt_pkg::REG_START_MODE:    start_mode_r    <= pwdata[rwbt_pkg::MODE_W-1:0];
        rwbt_pkg::REG_BOX_MIN_X:     box_min_x_r     <= pwdata[rwbt_pkg::COORD_W-1:0];
        rwbt_pkg::REG_BOX_MAX_X:     box_max_x_r     <= pwdata[rwbt_pkg::COORD_W-1:0];
        rwbt_pkg::REG_BOX_MIN_Y:     box_min_y_r     <= pwdata[rwbt_pkg::COORD_W-1:0];
        rwbt_pkg::REG_BOX_MAX_Y:     box_max_y_r     <= pwdata[rwbt_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rwbt_pkg::REG_FRAME_WIDTH:   prdata = DATW'(frame_width_r);
      rwbt_pkg::REG_FRAME_HEIGHT:  prdata = DATW'(frame_height_r);
      rwbt_pkg::REG_WINDOW_PIXELS: prdata = DATW'(window_pixels_r);
      rwbt_pkg::REG_START_MODE:    prdata = DATW'(start_mode_r);
      rwbt_pkg::REG_BOX_MIN_X:     prdata = DATW'(box_min_x_r);
      rwbt_pkg::REG_BOX_MAX_X:     prdata = DATW'(box_max_x_r);
      rwbt_pkg::REG_BOX_MIN_Y:     prdata = DATW'(box_min_y_r);
      rwbt_pkg::REG_BOX_MAX_Y:     prdata = DATW'(box_max_y_r);
      default:                     prdata = '0;
    endcase
  end

  // clamp at MAX_SIDE; frame size product is registered so the request
  // path only carries the row multiply
  assign side_w_nxt = (32'(frame_width_r) > 32'(MAX_SIDE)) ? DW'(MAX_SIDE) : frame_width_r;
  assign side_h_nxt = (32'(frame_height_r) > 32'(MAX_SIDE)) ? DW'(MAX_SIDE) : frame_height_r;

  always_ff @(posedge clk) begin
    side_w_r <= side_w_nxt;
    side_h_r <= side_h_nxt;
    total_r  <= XW'(side_w_r * side_h_r);
  end

  always_comb begin
    cfg.side_w        = side_w_r;
    cfg.side_h        = side_h_r;
    cfg.frame_total   = total_r;
    cfg.window_pixels = window_pixels_r;
    cfg.start_mode    = start_mode_r;
    cfg.box_min_x     = box_min_x_r;
    cfg.box_max_x     = box_max_x_r;
    cfg.box_min_y     = box_min_y_r;
    cfg.box_max_y     = box_max_y_r;
  end

endmodule

`default_nettype wire

FILE: design/rwbt_index_stage.sv
// Input register and index stage: box/frame test and linear pixel index.
// Depends on rwbt_pkg.
`default_nettype none

module rwbt_index_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rwbt_pkg::COORD_W-1:0]  in_x,
  input  wire logic [rwbt_pkg::COORD_W-1:0]  in_y,
  input  wire rwbt_pkg::cfg_t                cfg,
  output logic                               info_valid,
  input  wire logic                          info_ready,
  output rwbt_pkg::idx_info_t                info
);

  localparam int XW = rwbt_pkg::IDX_W;

  logic                         in_v_r, info_v_r;
  logic [rwbt_pkg::COORD_W-1:0] x_r, y_r;
  logic                         mid_ready;
  logic [rwbt_pkg::COORD_W+rwbt_pkg::DIM_W-1:0] row_prod;
  rwbt_pkg::idx_info_t          info_nxt, info_r;

  assign mid_ready = !info_v_r || info_ready;
  assign in_ready  = !in_v_r || mid_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      info_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (mid_ready) info_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= in_x;
      y_r <= in_y;
    end
    if (in_v_r && mid_ready) info_r <= info_nxt;
  end

  assign row_prod = y_r * cfg.side_w;

  always_comb begin
    info_nxt.counted  = (x_r >= cfg.box_min_x) && (x_r <= cfg.box_max_x) &&
                        (y_r >= cfg.box_min_y) && (y_r <= cfg.box_max_y) &&
                        ({1'b0, x_r} < cfg.side_w) && ({1'b0, y_r} < cfg.side_h);
    info_nxt.x        = x_r;
    info_nxt.row_base = XW'(row_prod);
    info_nxt.idx      = XW'(row_prod) + XW'(x_r);
  end

  assign info_valid = info_v_r;
  assign info       = info_r;

endmodule

`default_nettype wire

FILE: design/rwbt_window_stage.sv
// Window tracking stage: hit test, reload, fetch and request counters, result register.
// Depends on rwbt_pkg.
`default_nettype none

module rwbt_window_stage #(
  parameter int COUNT_BITS = rwbt_pkg::COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rwbt_pkg::cfg_t       cfg,
  input  wire logic                 info_valid,
  output logic                      info_ready,
  input  wire rwbt_pkg::idx_info_t  info,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output rwbt_pkg::res_t            res
);

  localparam int XW = rwbt_pkg::IDX_W;
  localparam int TW = rwbt_pkg::TOTAL_W;
  localparam int SW = rwbt_pkg::FSUM_W;
  localparam int LW = rwbt_pkg::FLOW_W;

  logic                         win_valid_r;
  logic [rwbt_pkg::IDX_W-1:0]   win_start_r, win_end_r;
  logic [COUNT_BITS-1:0]        req_cnt_r, req_cnt_nxt, load_cnt_r, load_cnt_nxt;
  logic [rwbt_pkg::FLOW_W-1:0]  fetch_low_r, fetch_low_nxt;
  logic [rwbt_pkg::FHIGH_W-1:0] fetch_high_r, fetch_high_nxt;
  logic                         res_v_r;
  rwbt_pkg::res_t               res_r;

  logic                         take, hit, reload, wp_covers, wrap;
  logic [rwbt_pkg::IDX_W-1:0]   start, room, wp_ext, len, add;
  logic [rwbt_pkg::FSUM_W-1:0]  fsum;

  assign info_ready = !res_v_r || res_ready;
  assign take       = info_valid && info_ready;

  always_comb begin
    case (cfg.start_mode)
      rwbt_pkg::MODE_COLUMN: start = XW'(info.x);
      rwbt_pkg::MODE_ROW:    start = info.row_base;
      default:               start = info.idx;
    endcase
  end

  // start is below the frame size for any counted request, so room >= 1
  assign room      = cfg.frame_total - start;
  assign wp_ext    = XW'(cfg.window_pixels);
  assign wp_covers = wp_ext >= room;
  assign len       = wp_covers ? room : wp_ext;
  assign add       = (wp_covers && (cfg.window_pixels != '0)) ? len - 1'b1 : len;

  assign hit    = info.counted && win_valid_r &&
                  (info.idx >= win_start_r) && (info.idx < win_end_r);
  assign reload = info.counted && !hit;

  // fetch_low stays below the wrap and add is far smaller, so one subtract suffices
  assign fsum = SW'(fetch_low_r) + SW'(add);
  assign wrap = fsum >= SW'(rwbt_pkg::FETCH_WRAP);

  always_comb begin
    req_cnt_nxt    = req_cnt_r;
    load_cnt_nxt   = load_cnt_r;
    fetch_low_nxt  = fetch_low_r;
    fetch_high_nxt = fetch_high_r;
    if (info.counted) req_cnt_nxt = req_cnt_r + 1'b1;
    if (reload) begin
      load_cnt_nxt   = load_cnt_r + 1'b1;
      fetch_low_nxt  = wrap ? LW'(fsum - SW'(rwbt_pkg::FETCH_WRAP)) : LW'(fsum);
      fetch_high_nxt = wrap ? fetch_high_r + 1'b1 : fetch_high_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r  <= 1'b0;
      win_start_r  <= '0;
      win_end_r    <= '0;
      req_cnt_r    <= '0;
      load_cnt_r   <= '0;
      fetch_low_r  <= '0;
      fetch_high_r <= '0;
      res_v_r      <= 1'b0;
    end else begin
      if (info_ready) res_v_r <= info_valid;
      if (take) begin
        req_cnt_r    <= req_cnt_nxt;
        load_cnt_r   <= load_cnt_nxt;
        fetch_low_r  <= fetch_low_nxt;
        fetch_high_r <= fetch_high_nxt;
        if (reload) begin
          win_valid_r <= 1'b1;
          win_start_r <= start;
          win_end_r   <= start + len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r.counted        <= info.counted;
      res_r.hit            <= hit;
      res_r.requests_total <= TW'(req_cnt_nxt);
      res_r.reloads_total  <= TW'(load_cnt_nxt);
      res_r.fetches_low    <= fetch_low_nxt;
      res_r.fetches_high   <= fetch_high_nxt;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for raster_window_buffer_tracker_unit.
// A scoreboard class predicts every result from the accepted requests; plain tasks drive
// the request channel and the APB port. Depends on rwbt_pkg, rwbt_req_if, rwbt_res_if.

class window_scoreboard;
  localparam int DW = rwbt_pkg::DIM_W;
  localparam int XW = rwbt_pkg::IDX_W;
  localparam int SW = rwbt_pkg::FSUM_W;

  // register copies
  logic [rwbt_pkg::DIM_W-1:0]   frame_w, frame_h;
  logic [rwbt_pkg::WP_W-1:0]    win_pixels;
  logic [rwbt_pkg::MODE_W-1:0]  mode;
  logic [rwbt_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y;
  // buffered window and running counters
  bit                           win_loaded;
  logic [rwbt_pkg::IDX_W-1:0]   win_lo, win_hi;
  logic [rwbt_pkg::TOTAL_W-1:0] req_count, load_count;
  logic [rwbt_pkg::FLOW_W-1:0]  fetch_lo;
  logic [rwbt_pkg::FHIGH_W-1:0] fetch_hi;
  rwbt_pkg::res_t               pending_results[$];
  int                           errors;
  int                           results_seen;

  function new();
    frame_w      = rwbt_pkg::RST_FRAME_WIDTH;
    frame_h      = rwbt_pkg::RST_FRAME_HEIGHT;
    win_pixels   = rwbt_pkg::RST_WINDOW_PIXELS;
    mode         = rwbt_pkg::RST_START_MODE;
    min_x        = rwbt_pkg::RST_BOX_MIN;
    max_x        = rwbt_pkg::RST_BOX_MAX;
    min_y        = rwbt_pkg::RST_BOX_MIN;
    max_y        = rwbt_pkg::RST_BOX_MAX;
    win_loaded   = 1'b0;
    win_lo       = '0;
    win_hi       = '0;
    req_count    = '0;
    load_count   = '0;
    fetch_lo     = '0;
    fetch_hi     = '0;
    errors       = 0;
    results_seen = 0;
  endfunction

  function void set_register(logic [rwbt_pkg::REG_IDX_W-1:0] index,
                             logic [rwbt_pkg::DATA_W-1:0] value);
    case (index)
      rwbt_pkg::REG_FRAME_WIDTH:   frame_w    = value[rwbt_pkg::DIM_W-1:0];
      rwbt_pkg::REG_FRAME_HEIGHT:  frame_h    = value[rwbt_pkg::DIM_W-1:0];
      rwbt_pkg::REG_WINDOW_PIXELS: win_pixels = value[rwbt_pkg::WP_W-1:0];
      rwbt_pkg::REG_START_MODE:    mode       = value[rwbt_pkg::MODE_W-1:0];
      rwbt_pkg::REG_BOX_MIN_X:     min_x      = value[rwbt_pkg::COORD_W-1:0];
      rwbt_pkg::REG_BOX_MAX_X:     max_x      = value[rwbt_pkg::COORD_W-1:0];
      rwbt_pkg::REG_BOX_MIN_Y:     min_y      = value[rwbt_pkg::COORD_W-1:0];
      rwbt_pkg::REG_BOX_MAX_Y:     max_y      = value[rwbt_pkg::COORD_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_request(logic [rwbt_pkg::COORD_W-1:0] x,
                             logic [rwbt_pkg::COORD_W-1:0] y);
    logic [rwbt_pkg::DIM_W-1:0]  w, h;
    logic [rwbt_pkg::IDX_W-1:0]  idx, total, start, room, len, add;
    logic [rwbt_pkg::FSUM_W-1:0] fsum;
    logic                        counted, hit;
    rwbt_pkg::res_t              r;
    w = (32'(frame_w) > rwbt_pkg::MAX_SIDE_DEF) ? DW'(rwbt_pkg::MAX_SIDE_DEF) : frame_w;
    h = (32'(frame_h) > rwbt_pkg::MAX_SIDE_DEF) ? DW'(rwbt_pkg::MAX_SIDE_DEF) : frame_h;
    counted = x >= min_x && x <= max_x && y >= min_y && y <= max_y &&
              {1'b0, x} < w && {1'b0, y} < h;
    hit = 1'b0;
    if (counted) begin
      idx   = y * w + x;
      total = w * h;
      hit   = win_loaded && idx >= win_lo && idx < win_hi;
      if (!hit) begin
        case (mode)
          rwbt_pkg::MODE_COLUMN: start = XW'(x);
          rwbt_pkg::MODE_ROW:    start = y * w;
          default:               start = idx;
        endcase
        room = total - start;
        len  = (XW'(win_pixels) < room) ? XW'(win_pixels) : room;
        // window running into the frame end fetches one less
        add  = (win_pixels != '0 && XW'(win_pixels) >= room) ? len - 1'b1 : len;
        win_loaded = 1'b1;
        win_lo     = start;
        win_hi     = start + len;
        fsum = SW'(fetch_lo) + SW'(add);
        if (fsum >= SW'(rwbt_pkg::FETCH_WRAP)) begin
          fsum     = fsum - SW'(rwbt_pkg::FETCH_WRAP);
          fetch_hi = fetch_hi + 1'b1;
        end
        fetch_lo   = fsum[rwbt_pkg::FLOW_W-1:0];
        load_count = load_count + 1'b1;
      end
      req_count = req_count + 1'b1;
    end
    r.counted        = counted;
    r.hit            = hit;
    r.requests_total = req_count;
    r.reloads_total  = load_count;
    r.fetches_low    = fetch_lo;
    r.fetches_high   = fetch_hi;
    pending_results.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task compare_field(string name, longint unsigned got_v, longint unsigned want_v);
    if (got_v !== want_v)
      report($sformatf("result %0d %s got %0d expected %0d", results_seen, name, got_v, want_v));
  endtask

  task match_result(rwbt_pkg::res_t got);
    rwbt_pkg::res_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0d arrived with no request pending", results_seen));
      return;
    end
    want = pending_results.pop_front();
    compare_field("counted", 64'(got.counted), 64'(want.counted));
    compare_field("hit", 64'(got.hit), 64'(want.hit));
    compare_field("requests_total", 64'(got.requests_total), 64'(want.requests_total));
    compare_field("reloads_total", 64'(got.reloads_total), 64'(want.reloads_total));
    compare_field("fetches_low", 64'(got.fetches_low), 64'(want.fetches_low));
    compare_field("fetches_high", 64'(got.fetches_high), 64'(want.fetches_high));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW   = rwbt_pkg::COORD_W;
  localparam int DATW = rwbt_pkg::DATA_W;
  localparam logic [rwbt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                        clk;
  logic                        rst_n;
  logic                        psel, penable, pwrite;
  logic [rwbt_pkg::ADDR_W-1:0] paddr;
  logic [rwbt_pkg::DATA_W-1:0] pwdata, prdata;
  logic                        pready;

  rwbt_req_if in_req();
  rwbt_res_if out_res();

  raster_window_buffer_tracker_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  window_scoreboard sb;

  int tx_idle_pct, rx_idle_pct;
  int hold_len;
  // generator view of the current phase: clamped frame, box, raster cursor
  int gw, gh, bx0, bx1, by0, by1;
  int cur_x, cur_y;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: check each transfer, then pick ready for the next edge
  initial begin
    rwbt_pkg::res_t got;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
        got.counted        = out_res.counted;
        got.hit            = out_res.hit;
        got.requests_total = out_res.requests_total;
        got.reloads_total  = out_res.reloads_total;
        got.fetches_low    = out_res.fetches_low;
        got.fetches_high   = out_res.fetches_high;
        sb.match_result(got);
      end
      if (hold_len > 0) begin
        out_res.ready <= 1'b0;
        hold_len--;
      end else begin
        out_res.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_pixel(input logic [rwbt_pkg::COORD_W-1:0] px,
                            input logic [rwbt_pkg::COORD_W-1:0] py);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.pixel_x <= px;
    in_req.pixel_y <= py;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    sb.take_request(px, py);
  endtask

  // leaves psel high so back-to-back writes chain; caller drops it
  task automatic write_reg(input logic [rwbt_pkg::REG_IDX_W-1:0] index,
                           input logic [rwbt_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_register(index, value);
  endtask

  task automatic wait_idle();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic setup_phase(input int w, input int h, input int wp,
                             input logic [rwbt_pkg::MODE_W-1:0] md,
                             input int x0, input int x1, input int y0, input int y1);
    write_reg(rwbt_pkg::REG_FRAME_WIDTH, DATW'(w));
    write_reg(rwbt_pkg::REG_FRAME_HEIGHT, DATW'(h));
    write_reg(rwbt_pkg::REG_WINDOW_PIXELS, DATW'(wp));
    write_reg(rwbt_pkg::REG_START_MODE, DATW'(md));
    write_reg(rwbt_pkg::REG_BOX_MIN_X, DATW'(x0));
    write_reg(rwbt_pkg::REG_BOX_MAX_X, DATW'(x1));
    write_reg(rwbt_pkg::REG_BOX_MIN_Y, DATW'(y0));
    write_reg(rwbt_pkg::REG_BOX_MAX_Y, DATW'(y1));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gw  = (w > rwbt_pkg::MAX_SIDE_DEF) ? rwbt_pkg::MAX_SIDE_DEF : w;
    gh  = (h > rwbt_pkg::MAX_SIDE_DEF) ? rwbt_pkg::MAX_SIDE_DEF : h;
    bx0 = x0;
    bx1 = x1;
    by0 = y0;
    by1 = y1;
    cur_x = (gw > 0 && x0 < gw) ? x0 : 0;
    cur_y = (gh > 0 && y0 < gh) ? y0 : 0;
  endtask

  function automatic int border_value(int lo, int hi, int side);
    case ($urandom_range(5))
      0: return lo - 1;
      1: return lo;
      2: return hi;
      3: return hi + 1;
      4: return side - 1;
      default: return side;
    endcase
  endfunction

  // mostly raster walks with skips, plus jumps, box hits, borders and noise
  task automatic pick_pixel(output logic [rwbt_pkg::COORD_W-1:0] px,
                            output logic [rwbt_pkg::COORD_W-1:0] py);
    int r;
    r = $urandom_range(99);
    if (gw == 0 || gh == 0 || r >= 90) begin
      px = CW'($urandom);
      py = CW'($urandom);
    end else if (r < 60) begin
      cur_x += ($urandom_range(3) == 0) ? $urandom_range(8, 2) : 1;
      while (cur_x >= gw) begin
        cur_x -= gw;
        cur_y++;
      end
      if (cur_y >= gh) cur_y = 0;
      px = CW'(cur_x);
      py = CW'(cur_y);
    end else if (r < 72) begin
      cur_x = $urandom_range(gw - 1);
      cur_y = $urandom_range(gh - 1);
      px = CW'(cur_x);
      py = CW'(cur_y);
    end else if (r < 80) begin
      px = CW'($urandom_range(bx1, bx0));
      py = CW'($urandom_range(by1, by0));
    end else begin
      px = CW'(border_value(bx0, bx1, gw));
      py = CW'(border_value(by0, by1, gh));
    end
  endtask

  initial begin
    logic [rwbt_pkg::COORD_W-1:0] px, py;
    int                           n_items;
    sb = new();
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_req.valid   <= 1'b0;
    in_req.pixel_x <= '0;
    in_req.pixel_y <= '0;
    tx_idle_pct = 8;
    rx_idle_pct = 64;
    hold_len    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: first load, hit, last pixel, frame edges, bit patterns
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd3839, 12'd2159);
    send_pixel(12'd3840, 12'd5);
    send_pixel(12'd7, 12'd2160);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2047, 12'd1024);
    send_pixel(12'd2048, 12'd1024);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'h2AA);
    send_pixel(12'd0, 12'd55);
    send_pixel(12'd3839, 12'd0);
    in_req.valid <= 1'b0;

    for (int p = 1; p <= 13; p++) begin
      wait_idle();
      if (p <= 4) begin
        tx_idle_pct = 8;
        rx_idle_pct = 64;
      end else if (p <= 8) begin
        tx_idle_pct = 64;
        rx_idle_pct = 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        1: begin
          setup_phase(64, 32, 100, rwbt_pkg::MODE_PIXEL, 0, 4095, 0, 4095);
          n_items = 140;
        end
        2: begin
          setup_phase(64, 32, 16, rwbt_pkg::MODE_COLUMN, 4, 50, 2, 28);
          n_items = 140;
        end
        3: begin
          setup_phase(64, 32, 200, rwbt_pkg::MODE_ROW, 0, 63, 0, 31);
          n_items = 140;
        end
        4: begin
          setup_phase(100, 40, 5000, MODE_UNUSED, 0, 4095, 0, 4095);
          n_items = 140;
        end
        5: begin
          setup_phase(37, 19, 0, rwbt_pkg::MODE_PIXEL, 3, 30, 1, 17);
          n_items = 120;
        end
        6: begin
          setup_phase(0, 50, 64, rwbt_pkg::MODE_PIXEL, 0, 4095, 0, 4095);
          n_items = 40;
        end
        7: begin
          setup_phase(8191, 8191, 16777216, rwbt_pkg::MODE_PIXEL, 0, 4095, 0, 4095);
          n_items = 160;
        end
        8: begin
          setup_phase(4096, 4096, 33554431, rwbt_pkg::MODE_COLUMN, 4000, 4095, 0, 4095);
          n_items = 140;
        end
        9: begin
          setup_phase(1, 1, 1, rwbt_pkg::MODE_ROW, 0, 0, 0, 0);
          n_items = 40;
        end
        10: begin
          setup_phase(320, 240, 1000, rwbt_pkg::MODE_ROW, 10, 300, 5, 200);
          n_items = 200;
        end
        11: begin
          setup_phase(5000, 0, 214016, rwbt_pkg::MODE_PIXEL, 0, 4095, 0, 4095);
          n_items = 30;
        end
        12: begin
          setup_phase(3840, 2160, 214016, rwbt_pkg::MODE_COLUMN, 100, 50, 0, 4095);
          n_items = 30;
        end
        default: begin
          setup_phase(3840, 2160, 214016, rwbt_pkg::MODE_PIXEL, 0, 4095, 0, 4095);
          n_items = 160;
        end
      endcase
      // long receiver stall while requests keep coming: pipeline fills, input backs up
      if (p == 10) hold_len = 300;
      repeat (n_items) begin
        pick_pixel(px, py);
        send_pixel(px, py);
      end
      in_req.valid <= 1'b0;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
